/* rtl/ssq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted sleep timer queue package
// Widths, codes, entry type and sleep time clamp shared by the queue modules.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int DEPTH      = 16;
  localparam int TIME_WIDTH = 16;
  localparam int ID_W       = 8;
  localparam int SLEEP_W    = 16;
  localparam int KIND_W     = 2;
  localparam int CMP_W      = (TIME_WIDTH > SLEEP_W) ? TIME_WIDTH : SLEEP_W;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [ID_W-1:0]       id_t;
  typedef logic [KIND_W-1:0]     kind_t;

  localparam kind_t KIND_ACCEPT = 2'd0;
  localparam kind_t KIND_REJECT = 2'd1;
  localparam kind_t KIND_WOKEN  = 2'd2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_PUT  = 1'b1;

  localparam time_t TIME_MAX = {TIME_WIDTH{1'b1}};

  typedef struct packed {
    logic  valid;
    id_t   id;
    time_t remaining;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DECR,
    OP_POP
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_WAKE
  } state_t;

  function automatic time_t clamp_time(input logic [SLEEP_W-1:0] t);
    logic [CMP_W-1:0] tw;
    tw = CMP_W'(t);
    if (tw == '0) begin
      tw = CMP_W'(1);
    end
    if (tw > CMP_W'(TIME_MAX)) begin
      tw = CMP_W'(TIME_MAX);
    end
    return TIME_WIDTH'(tw);
  endfunction

endpackage : ssq_pkg
`default_nettype wire

/* rtl/sorted_sleep_timer_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted sleep timer queue
// Row of cells kept sorted by remaining ticks; puts insert (or are rejected
// when the row is full), ticks age and wake the threads that reach zero.
// ----------------------------------------------------------------------------
// A put's result appears in the output register in the cycle after the put
// is taken; a put waits while that register holds an untaken result.
// A tick ages every cell at once, then each woken thread leaves the head of
// the chain at one per cycle, unless the output stalls, through the single
// output register; no new item is taken until the wake-ups are drained.
// ----------------------------------------------------------------------------
module sorted_sleep_timer_queue_top
  import ssq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic [ID_W-1:0]    in_thread_id,
  input  wire logic [SLEEP_W-1:0] in_sleep_time,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [KIND_W-1:0]       out_kind,
  output logic [ID_W-1:0]         out_woken_id,
  output logic                    out_last
);

  state_t   state_r, state_nxt;
  cell_op_t cell_op;
  entry_t   cells [0:DEPTH];
  logic     ins_vec [0:DEPTH-1];
  logic [DEPTH-1:0] valid_vec;
  time_t    new_time;

  logic  out_valid_r, out_valid_nxt;
  kind_t out_kind_r, out_kind_nxt;
  id_t   out_id_r, out_id_nxt;
  logic  out_last_r, out_last_nxt;

  logic in_fire, out_free, full, head_due, wake_last, wake_now;

  assign new_time  = clamp_time(in_sleep_time);
  assign cells[DEPTH] = '0;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign full      = cells[DEPTH-1].valid;
  assign head_due  = cells[0].valid && (cells[0].remaining == '0);
  assign wake_last = !(cells[1].valid && (cells[1].remaining == '0));
  assign wake_now  = (state_r == ST_WAKE) && head_due && out_free;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign valid_vec[g] = cells[g].valid;
    ssq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (cell_op),
      .new_id     (in_thread_id),
      .new_time   (new_time),
      .prev_entry ((g == 0) ? entry_t'('0) : cells[(g == 0) ? 0 : g-1]),
      .prev_ins   ((g == 0) ? 1'b0 : ins_vec[(g == 0) ? 0 : g-1]),
      .next_entry (cells[g+1]),
      .cur_entry  (cells[g]),
      .ins        (ins_vec[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_command == CMD_TICK)) begin
          state_nxt = ST_WAKE;
        end
      end
      ST_WAKE: begin
        if (!head_due) begin
          state_nxt = ST_IDLE;
        end else if (out_free && wake_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cell_op  = OP_HOLD;
    case (state_r)
      ST_IDLE: begin
        in_stall = (in_command == CMD_PUT) && !out_free;
        if (in_fire) begin
          if (in_command == CMD_TICK) begin
            cell_op = OP_DECR;
          end else if (!full) begin
            cell_op = OP_INSERT;
          end
        end
      end
      ST_WAKE: begin
        if (wake_now) begin
          cell_op = OP_POP;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    if (in_fire && (in_command == CMD_PUT)) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = full ? KIND_REJECT : KIND_ACCEPT;
      out_id_nxt    = in_thread_id;
      out_last_nxt  = 1'b1;
    end else if (wake_now) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = KIND_WOKEN;
      out_id_nxt    = cells[0].id;
      out_last_nxt  = wake_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_woken_id = out_id_r;
  assign out_last     = out_last_r;

  a_occupied_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("occupied cells do not form a prefix of the chain");

  a_idle_head_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && cells[0].valid |-> cells[0].remaining != '0)
    else $error("expired entry left at the head while idle");

  a_put_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_command == CMD_PUT) |=> out_valid_r)
    else $error("put transfer gave no result");

  a_pop_due: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_op == OP_POP) |=> $past(head_due) && out_valid_r && (out_kind_r == KIND_WOKEN))
    else $error("head popped without a wake-up result");

endmodule : sorted_sleep_timer_queue_top
`default_nettype wire

/* rtl/ssq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted sleep timer queue cell
// One queue slot: inserts from its upper neighbour or the new item, ages,
// or takes its lower neighbour's entry when the head leaves.
// ----------------------------------------------------------------------------
module ssq_cell
  import ssq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cell_op_t op,
  input  wire id_t      new_id,
  input  wire time_t    new_time,
  input  wire entry_t   prev_entry,
  input  wire logic     prev_ins,
  input  wire entry_t   next_entry,
  output entry_t        cur_entry,
  output logic          ins
);

  logic  valid_r, valid_nxt;
  id_t   id_r, id_nxt;
  time_t rem_r, rem_nxt;

  assign ins       = !valid_r || (rem_r >= new_time);
  assign cur_entry = '{valid: valid_r, id: id_r, remaining: rem_r};

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    rem_nxt   = rem_r;
    case (op)
      OP_INSERT: begin
        if (prev_ins) begin
          valid_nxt = prev_entry.valid;
          id_nxt    = prev_entry.id;
          rem_nxt   = prev_entry.remaining;
        end else if (ins) begin
          valid_nxt = 1'b1;
          id_nxt    = new_id;
          rem_nxt   = new_time;
        end
      end
      OP_DECR: begin
        if (valid_r && (rem_r != '0)) begin
          rem_nxt = rem_r - time_t'(1);
        end
      end
      OP_POP: begin
        valid_nxt = next_entry.valid;
        id_nxt    = next_entry.id;
        rem_nxt   = next_entry.remaining;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r  <= id_nxt;
    rem_r <= rem_nxt;
  end

endmodule : ssq_cell
`default_nettype wire
